// ----- hdl/matrix_add_multiply_engine_core_defines.svh -----
// Assertion macros used by the matrix engine datapath.
`ifndef MATRIX_ADD_MULTIPLY_ENGINE_CORE_DEFINES_SVH
`define MATRIX_ADD_MULTIPLY_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define MAME_ASSERT_NOW(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define MAME_ASSERT_NEXT(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error("%m: next-cycle check failed");

`endif

// ----- hdl/mame_pkg.sv -----
`default_nettype none

package mame_pkg;

   // Fixed matrix geometry and field widths.
   localparam int MAX_DIM = 4;
   localparam int DIM_W   = 2;
   localparam int ADDR_W  = 2 * DIM_W;
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int DATA_W  = 32;
   localparam int CFG_W   = 3;
   localparam int CSR_IDX_W = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

   // Result kind codes.
   localparam logic KIND_SUM     = 1'b0;
   localparam logic KIND_PRODUCT = 1'b1;

   // Tags that travel with one step through the datapath.
   typedef struct packed {
      logic             kind;
      logic [DIM_W-1:0] row;
      logic [DIM_W-1:0] col;
      logic             first_k;
      logic             last_k;
      logic             size_error;
      logic             last_result;
   } mame_tag_type;

   // One compute step: read, multiply or add, accumulate.
   typedef struct packed {
      logic             valid;
      logic [DIM_W-1:0] k;
      mame_tag_type     tag;
   } mame_cmd_type;

   // One element write into a matrix store.
   typedef struct packed {
      logic             valid;
      logic             second;
      logic [DIM_W-1:0] row;
      logic [DIM_W-1:0] col;
   } mame_wr_type;

   // Datapath status seen by the controller.
   typedef struct packed {
      logic busy;
      logic out_free;
   } mame_status_type;

endpackage

`default_nettype wire

// ----- hdl/mame_req_if.sv -----
`default_nettype none

interface mame_req_if import mame_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] element_value;

   modport source (output valid, output element_value, input ready);
   modport sink   (input valid, input element_value, output ready);
endinterface

`default_nettype wire

// ----- hdl/mame_rsp_if.sv -----
`default_nettype none

interface mame_rsp_if import mame_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] result_value;
   logic                     result_kind;
   logic [DIM_W-1:0]         row_index;
   logic [DIM_W-1:0]         column_index;
   logic                     size_error;
   logic                     last_result;

   modport source (output valid, output result_value, output result_kind,
                   output row_index, output column_index, output size_error,
                   output last_result, input ready);
   modport sink   (input valid, input result_value, input result_kind,
                   input row_index, input column_index, input size_error,
                   input last_result, output ready);
endinterface

`default_nettype wire

// ----- hdl/mame_datapath.sv -----
`default_nettype none
`include "matrix_add_multiply_engine_core_defines.svh"

module mame_datapath import mame_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [DATA_W-1:0] load_data,
   input  wire mame_wr_type       wr,
   input  wire mame_cmd_type      cmd,
   output mame_status_type        status,
   mame_rsp_if.source             rsp_ch
);

   // Matrix stores, row-major at row * MAX_DIM + column.
   logic [DATA_W-1:0] first_mem [DEPTH];
   logic [DATA_W-1:0] second_mem [DEPTH];

   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] addr_a;
   logic [ADDR_W-1:0] addr_b;

   logic              s1_valid_ff;
   mame_tag_type      s1_tag_ff;
   logic [DATA_W-1:0] a_ff;
   logic [DATA_W-1:0] b_ff;

   logic              s2_valid_ff;
   mame_tag_type      s2_tag_ff;
   logic [DATA_W-1:0] term_ff;
   logic [DATA_W-1:0] term_in;

   logic [DATA_W-1:0] acc_ff;
   logic [DATA_W-1:0] acc_in;

   logic              out_valid_ff;
   logic              out_valid_in;
   logic [DATA_W-1:0] out_value_ff;
   mame_tag_type      out_tag_ff;

   // Addresses: a sum reads the same cell of both, a product walks row by column.
   assign wr_addr = {wr.row, wr.col};
   assign addr_a  = (cmd.tag.kind == KIND_SUM) ? {cmd.tag.row, cmd.tag.col}
                                               : {cmd.tag.row, cmd.k};
   assign addr_b  = (cmd.tag.kind == KIND_SUM) ? {cmd.tag.row, cmd.tag.col}
                                               : {cmd.k, cmd.tag.col};

   // Store writes and registered reads.
   always_ff @(posedge clock) begin
      if (wr.valid && !wr.second) begin
         first_mem[wr_addr] <= load_data;
      end
      if (wr.valid && wr.second) begin
         second_mem[wr_addr] <= load_data;
      end
      if (cmd.valid) begin
         a_ff <= first_mem[addr_a];
         b_ff <= second_mem[addr_b];
      end
   end

   // Second stage forms the sum or the low half of the product.
   always_comb begin
      if (s1_tag_ff.kind == KIND_SUM) begin
         term_in = a_ff + b_ff;
      end else begin
         term_in = a_ff * b_ff;
      end
   end

   // Third stage accumulates and lands the finished word in the output register.
   assign acc_in = (s2_tag_ff.first_k ? '0 : acc_ff) + term_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      if (s2_valid_ff && s2_tag_ff.last_k) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= cmd.valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= out_valid_in;
      end
      s1_tag_ff <= cmd.tag;
      s2_tag_ff <= s1_tag_ff;
      term_ff   <= term_in;
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
      if (s2_valid_ff && s2_tag_ff.last_k) begin
         out_value_ff <= acc_in;
         out_tag_ff   <= s2_tag_ff;
      end
   end

   assign status.busy     = s1_valid_ff | s2_valid_ff;
   assign status.out_free = ~out_valid_ff;

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.result_value = out_value_ff;
   assign rsp_ch.result_kind  = out_tag_ff.kind;
   assign rsp_ch.row_index    = out_tag_ff.row;
   assign rsp_ch.column_index = out_tag_ff.col;
   assign rsp_ch.size_error   = out_tag_ff.size_error;
   assign rsp_ch.last_result  = out_tag_ff.last_result;

   // A finished word never overwrites one that is still waiting.
   `MAME_ASSERT_NOW(a_land_free, s2_valid_ff && s2_tag_ff.last_k, !out_valid_ff)
   // A new element starts only with the pipeline empty.
   `MAME_ASSERT_NOW(a_start_empty, cmd.valid && cmd.tag.first_k, !s1_valid_ff && !s2_valid_ff)
   // Loading and computing never share a cycle.
   `MAME_ASSERT_NOW(a_wr_no_cmd, wr.valid, !cmd.valid)
   // Product words only come from square runs.
   `MAME_ASSERT_NEXT(a_prod_square, s2_valid_ff && s2_tag_ff.last_k && s2_tag_ff.kind == KIND_PRODUCT, !out_tag_ff.size_error)

endmodule

`default_nettype wire

// ----- hdl/mame_controller.sv -----
`default_nettype none

module mame_controller import mame_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_write_data,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire mame_status_type      status,
   output mame_wr_type               wr,
   output mame_cmd_type              cmd
);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_WAIT,
      ST_ISSUE
   } state_type;

   // Size register clipped into a last index: zero acts as one, large as MAX_DIM.
   function automatic logic [DIM_W-1:0] last_index(input logic [CFG_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (v > CFG_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM - 1);
      end else begin
         r = DIM_W'(v - CFG_W'(1));
      end
      return r;
   endfunction

   state_type        state_ff, state_in;
   logic [CFG_W-1:0] row_count_ff, row_count_in;
   logic [CFG_W-1:0] column_count_ff, column_count_in;
   logic             phase_ff, phase_in;
   logic [DIM_W-1:0] lrow_ff, lrow_in;
   logic [DIM_W-1:0] lcol_ff, lcol_in;
   logic [DIM_W-1:0] erow_ff, erow_in;
   logic [DIM_W-1:0] ecol_ff, ecol_in;
   logic [DIM_W-1:0] ek_ff, ek_in;
   logic             kind_ff, kind_in;

   logic [DIM_W-1:0] rows_last;
   logic [DIM_W-1:0] cols_last;
   logic             square;
   logic             accept;

   assign rows_last = last_index(row_count_ff);
   assign cols_last = last_index(column_count_ff);
   assign square    = (rows_last == cols_last);
   assign req_ready = (state_ff == ST_LOAD);
   assign accept    = req_valid && req_ready;

   // Commands to the datapath.
   always_comb begin
      wr.valid  = accept;
      wr.second = phase_ff;
      wr.row    = lrow_ff;
      wr.col    = lcol_ff;

      cmd.valid           = (state_ff == ST_ISSUE);
      cmd.k               = ek_ff;
      cmd.tag.kind        = kind_ff;
      cmd.tag.row         = erow_ff;
      cmd.tag.col         = ecol_ff;
      cmd.tag.first_k     = (kind_ff == KIND_SUM) || (ek_ff == '0);
      cmd.tag.last_k      = (kind_ff == KIND_SUM) || (ek_ff == cols_last);
      cmd.tag.size_error  = ~square;
      cmd.tag.last_result = ((kind_ff == KIND_PRODUCT) || !square) &&
                            (erow_ff == rows_last) && (ecol_ff == cols_last);
   end

   // Next state: load counters, emit counters and configuration.
   always_comb begin
      state_in        = state_ff;
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      phase_in        = phase_ff;
      lrow_in         = lrow_ff;
      lcol_in         = lcol_ff;
      erow_in         = erow_ff;
      ecol_in         = ecol_ff;
      ek_in           = ek_ff;
      kind_in         = kind_ff;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (lcol_ff == cols_last) begin
                  lcol_in = '0;
                  if (lrow_ff == rows_last) begin
                     lrow_in  = '0;
                     phase_in = ~phase_ff;
                     if (phase_ff) begin
                        state_in = ST_WAIT;
                        erow_in  = '0;
                        ecol_in  = '0;
                        ek_in    = '0;
                        kind_in  = KIND_SUM;
                     end
                  end else begin
                     lrow_in = lrow_ff + DIM_W'(1);
                  end
               end else begin
                  lcol_in = lcol_ff + DIM_W'(1);
               end
            end
         end
         ST_WAIT: begin
            if (!status.busy && status.out_free) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (cmd.tag.last_k) begin
               ek_in    = '0;
               state_in = ST_WAIT;
               if (ecol_ff == cols_last) begin
                  ecol_in = '0;
                  if (erow_ff == rows_last) begin
                     erow_in = '0;
                     if ((kind_ff == KIND_SUM) && square) begin
                        kind_in = KIND_PRODUCT;
                     end else begin
                        state_in = ST_LOAD;
                     end
                  end else begin
                     erow_in = erow_ff + DIM_W'(1);
                  end
               end else begin
                  ecol_in = ecol_ff + DIM_W'(1);
               end
            end else begin
               ek_in = ek_ff + DIM_W'(1);
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      // A size write drops any partial load.
      if (csr_write_enable) begin
         case (csr_index)
            REG_ROW_COUNT: begin
               row_count_in = csr_write_data;
               phase_in     = 1'b0;
               lrow_in      = '0;
               lcol_in      = '0;
            end
            REG_COLUMN_COUNT: begin
               column_count_in = csr_write_data;
               phase_in        = 1'b0;
               lrow_in         = '0;
               lcol_in         = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         row_count_ff    <= CFG_W'(MAX_DIM);
         column_count_ff <= CFG_W'(MAX_DIM);
         phase_ff        <= 1'b0;
         lrow_ff         <= '0;
         lcol_ff         <= '0;
         erow_ff         <= '0;
         ecol_ff         <= '0;
         ek_ff           <= '0;
         kind_ff         <= KIND_SUM;
      end else begin
         state_ff        <= state_in;
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
         phase_ff        <= phase_in;
         lrow_ff         <= lrow_in;
         lcol_ff         <= lcol_in;
         erow_ff         <= erow_in;
         ecol_ff         <= ecol_in;
         ek_ff           <= ek_in;
         kind_ff         <= kind_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/matrix_add_multiply_engine_core.sv -----
// Integer matrix add and multiply engine.
// Sizes are set on the csr_ port (index 0 rows, index 1 columns, 1 to 4 each,
// zero acting as one and larger values as four); a size write drops any partial load.
// Words on req_ch carry matrix elements: the whole first matrix, then the
// second, both row-major, one word per cycle while loading.
// After the last element the block stops taking words and sends on rsp_ch the
// element-wise sum in row-major order, then, for a square size only, the
// product in row-major order. A non-square run flags size_error on every word
// and marks its last sum word with last_result.
// Each result word passes through a three-stage datapath (store read, multiply
// or add, accumulate); a product word is built up by the single shared
// multiplier walking the inner index once per cycle. Loading resumes as soon as
// the final step of a run is issued.
// A stalled rsp_ch holds its word in the output register and the next word is
// not started until it is taken. Reset returns both sizes to four and empties
// the load; stored elements are not cleared.
`default_nettype none

module matrix_add_multiply_engine_core import mame_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_write_data,
   mame_req_if.sink                  req_ch,
   mame_rsp_if.source                rsp_ch
);

   mame_wr_type     wr;
   mame_cmd_type    cmd;
   mame_status_type status;

   // Sequencing of load and emit.
   mame_controller u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .status           (status),
      .wr               (wr),
      .cmd              (cmd)
   );

   // Stores, multiplier, accumulator and output register.
   mame_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .load_data (req_ch.element_value),
      .wr        (wr),
      .cmd       (cmd),
      .status    (status),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- dv/matrix_add_multiply_engine_core_tb.sv -----
`timescale 1ns / 1ps

module matrix_add_multiply_engine_core_tb import mame_pkg::*; ();

   // Run length, idle time before a register write, and the hang guard.
   localparam int RANDOM_ITEMS  = 100;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int MAX_GAP       = 19;

   // Indexes with no register behind them: writes to them are ignored.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_3 = 2'd3;

   // One result word as it appears on the response channel.
   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              kind;
      logic [DIM_W-1:0]  row;
      logic [DIM_W-1:0]  col;
      logic              size_error;
      logic              last_result;
   } matrix_word_type;

   // One row of the directed table: an element word or a register write.
   typedef enum logic {STEP_ELEMENT, STEP_REGISTER} step_op_type;

   typedef struct {
      step_op_type          op;
      logic [CSR_IDX_W-1:0] index;
      logic [CFG_W-1:0]     data;
      logic [DATA_W-1:0]    value;
      int                   typed_count;
      matrix_word_type      typed_first;
      matrix_word_type      typed_second;
   } directed_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_write_data;

   mame_req_if req_if ();
   mame_rsp_if rsp_if ();

   matrix_add_multiply_engine_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_if),
      .rsp_ch           (rsp_if)
   );

   always #5 clock = ~clock;

   // Shadow copy of the engine state used for prediction.
   logic [CFG_W-1:0]  shadow_rows;
   logic [CFG_W-1:0]  shadow_cols;
   logic [DATA_W-1:0] shadow_first [DEPTH];
   logic [DATA_W-1:0] shadow_second [DEPTH];
   int unsigned       shadow_load_pos;

   matrix_word_type pending_words[$];
   directed_step_type directed_steps[$];
   int  error_count = 0;
   int  cycle_count = 0;
   bit  quiet_spell = 1'b0;
   bit  request_held = 1'b0;

   // A zero size acts as one and anything above the maximum as the maximum.
   function automatic int unsigned effective_size(input logic [CFG_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_DIM) return MAX_DIM;
      return 32'(raw);
   endfunction

   // Store address of a matrix element, row-major with a fixed row pitch.
   function automatic logic [ADDR_W-1:0] cell_addr(input int unsigned row,
                                                   input int unsigned col);
      return ADDR_W'(row * MAX_DIM + col);
   endfunction

   // A write to a real register restarts the load; other indexes are ignored.
   function automatic void apply_register_write(input logic [CSR_IDX_W-1:0] index,
                                                input logic [CFG_W-1:0] data);
      if (index == REG_ROW_COUNT) shadow_rows = data;
      else if (index == REG_COLUMN_COUNT) shadow_cols = data;
      else return;
      shadow_load_pos = 0;
   endfunction

   function automatic matrix_word_type make_word(input logic [DATA_W-1:0] value,
                                                 input logic kind,
                                                 input logic [DIM_W-1:0] row,
                                                 input logic [DIM_W-1:0] col,
                                                 input logic size_error,
                                                 input logic last_result);
      matrix_word_type w;
      w.value       = value;
      w.kind        = kind;
      w.row         = row;
      w.col         = col;
      w.size_error  = size_error;
      w.last_result = last_result;
      return w;
   endfunction

   // Stores one element and, on completing the second matrix with keep set, works out the
   // sum words and, for a square size, the product words.
   function automatic void load_element(input logic [DATA_W-1:0] value, input bit keep);
      int unsigned rows, cols, total, pos;
      bit square;
      logic [DATA_W-1:0] acc;
      rows   = effective_size(shadow_rows);
      cols   = effective_size(shadow_cols);
      total  = rows * cols;
      square = (rows == cols);
      if (shadow_load_pos >= 2 * total) shadow_load_pos = 0;
      pos = shadow_load_pos;
      if (pos < total) begin
         shadow_first[cell_addr(pos / cols, pos % cols)] = value;
      end else begin
         pos = pos - total;
         shadow_second[cell_addr(pos / cols, pos % cols)] = value;
      end
      shadow_load_pos++;
      if (shadow_load_pos < 2 * total) return;
      shadow_load_pos = 0;
      if (!keep) return;
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < cols; c++) begin
            pending_words.push_back(make_word(
               shadow_first[cell_addr(r, c)] + shadow_second[cell_addr(r, c)],
               KIND_SUM, r[DIM_W-1:0], c[DIM_W-1:0], !square,
               !square && r == rows - 1 && c == cols - 1));
         end
      end
      if (square) begin
         for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
               acc = '0;
               for (int k = 0; k < cols; k++) begin
                  acc = acc + shadow_first[cell_addr(r, k)] *
                              shadow_second[cell_addr(k, c)];
               end
               pending_words.push_back(make_word(acc, KIND_PRODUCT, r[DIM_W-1:0],
                  c[DIM_W-1:0], 1'b0, r == rows - 1 && c == cols - 1));
            end
         end
      end
   endfunction

   // Table row builders.
   function automatic directed_step_type element_step(input logic [DATA_W-1:0] value);
      directed_step_type s;
      s.op           = STEP_ELEMENT;
      s.index        = REG_ROW_COUNT;
      s.data         = '0;
      s.value        = value;
      s.typed_count  = 0;
      s.typed_first  = '0;
      s.typed_second = '0;
      return s;
   endfunction

   function automatic directed_step_type register_step(input logic [CSR_IDX_W-1:0] index,
                                                       input logic [CFG_W-1:0] data);
      directed_step_type s;
      s       = element_step('0);
      s.op    = STEP_REGISTER;
      s.index = index;
      s.data  = data;
      return s;
   endfunction

   function automatic directed_step_type checked_step(input logic [DATA_W-1:0] value,
                                                      input int typed_count,
                                                      input matrix_word_type first_word,
                                                      input matrix_word_type second_word);
      directed_step_type s;
      s              = element_step(value);
      s.typed_count  = typed_count;
      s.typed_first  = first_word;
      s.typed_second = second_word;
      return s;
   endfunction

   // Drops valid after the last accepted word, unless it is already low.
   task automatic release_request();
      if (request_held) begin
         req_if.valid <= 1'b0;
         request_held = 1'b0;
      end
   endtask

   // Sends one element word after a random gap and predicts on acceptance.
   task automatic send_element(input logic [DATA_W-1:0] value, input bit keep);
      int gap;
      gap = quiet_spell ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         release_request();
         repeat (gap) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.element_value <= value;
      request_held = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      load_element(value, keep);
   endtask

   // Waits until every predicted word has been taken and the engine settles.
   task automatic wait_idle();
      release_request();
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CFG_W-1:0] data);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      apply_register_write(index, data);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly legal sizes, now and then zero or above the maximum.
   function automatic logic [CFG_W-1:0] pick_size();
      if ($urandom_range(0, 3) == 0) return CFG_W'($urandom_range(0, 7));
      return CFG_W'($urandom_range(1, MAX_DIM));
   endfunction

   // Element values: full-width random, small values and the extremes.
   function automatic logic [DATA_W-1:0] pick_element();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0: return 32'h0000_0000;
               1: return 32'h0000_0001;
               2: return 32'hffff_ffff;
               3: return 32'h7fff_ffff;
               default: return 32'h8000_0000;
            endcase
         end
         1: return $urandom_range(0, 15) - 8;
         default: return $urandom;
      endcase
   endfunction

   // Response side: a fresh stall is drawn for every word.
   initial begin : response_driver
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = quiet_spell ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // Compares every accepted result word with the oldest prediction.
   always @(posedge clock) begin : result_checker
      matrix_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_words.size() == 0) begin
            $error("result word with nothing expected: result_value %0d",
                   $signed(rsp_if.result_value));
            error_count++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_if.result_value !== want.value) begin
               $error("result_value mismatch: expected %0d, actual %0d",
                      $signed(want.value), $signed(rsp_if.result_value));
               error_count++;
            end
            if (rsp_if.result_kind !== want.kind) begin
               $error("result_kind mismatch: expected %0d, actual %0d",
                      want.kind, rsp_if.result_kind);
               error_count++;
            end
            if (rsp_if.row_index !== want.row) begin
               $error("row_index mismatch: expected %0d, actual %0d",
                      want.row, rsp_if.row_index);
               error_count++;
            end
            if (rsp_if.column_index !== want.col) begin
               $error("column_index mismatch: expected %0d, actual %0d",
                      want.col, rsp_if.column_index);
               error_count++;
            end
            if (rsp_if.size_error !== want.size_error) begin
               $error("size_error mismatch: expected %0d, actual %0d",
                      want.size_error, rsp_if.size_error);
               error_count++;
            end
            if (rsp_if.last_result !== want.last_result) begin
               $error("last_result mismatch: expected %0d, actual %0d",
                      want.last_result, rsp_if.last_result);
               error_count++;
            end
         end
      end
   end

   // Hang guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Main sequence: reset, directed table, then random phases.
   initial begin : stimulus
      int sent;
      int runs;
      int total;
      logic [CFG_W-1:0] rows_data;
      logic [CFG_W-1:0] cols_data;

      csr_write_enable     = 1'b0;
      csr_index            = '0;
      csr_write_data       = '0;
      req_if.valid         = 1'b0;
      req_if.element_value = '0;
      rsp_if.ready         = 1'b0;

      shadow_rows     = 3'd4;
      shadow_cols     = 3'd4;
      shadow_load_pos = 0;
      shadow_first    = '{default: '0};
      shadow_second   = '{default: '0};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A partial load at the reset size, dropped by the following write.
      directed_steps.push_back(element_step(32'h7fff_ffff));
      directed_steps.push_back(element_step(32'h8000_0000));
      // Zero sizes act as one by one; the extremes of the element range.
      directed_steps.push_back(register_step(REG_ROW_COUNT, 3'd0));
      directed_steps.push_back(register_step(REG_COLUMN_COUNT, 3'd0));
      directed_steps.push_back(element_step(32'h7fff_ffff));
      directed_steps.push_back(checked_step(32'h7fff_ffff, 2,
         make_word(32'hffff_fffe, KIND_SUM, 2'd0, 2'd0, 1'b0, 1'b0),
         make_word(32'h0000_0001, KIND_PRODUCT, 2'd0, 2'd0, 1'b0, 1'b1)));
      directed_steps.push_back(element_step(32'h8000_0000));
      directed_steps.push_back(checked_step(32'h8000_0000, 2,
         make_word(32'h0000_0000, KIND_SUM, 2'd0, 2'd0, 1'b0, 1'b0),
         make_word(32'h0000_0000, KIND_PRODUCT, 2'd0, 2'd0, 1'b0, 1'b1)));
      directed_steps.push_back(element_step(32'hffff_ffff));
      directed_steps.push_back(checked_step(32'h0000_0001, 2,
         make_word(32'h0000_0000, KIND_SUM, 2'd0, 2'd0, 1'b0, 1'b0),
         make_word(32'hffff_ffff, KIND_PRODUCT, 2'd0, 2'd0, 1'b0, 1'b1)));
      // Rows above the maximum act as four: a tall non-square run.
      directed_steps.push_back(register_step(REG_ROW_COUNT, 3'd7));
      directed_steps.push_back(register_step(REG_COLUMN_COUNT, 3'd1));
      directed_steps.push_back(element_step(32'h0000_0000));
      directed_steps.push_back(element_step(32'h0000_0001));
      directed_steps.push_back(element_step(32'hffff_ffff));
      directed_steps.push_back(element_step(32'h8000_0000));
      directed_steps.push_back(element_step(32'h7fff_ffff));
      directed_steps.push_back(element_step(32'hffff_ffff));
      directed_steps.push_back(element_step(32'h0000_0001));
      directed_steps.push_back(element_step(32'h8000_0000));
      // A wide non-square run, with an ignored write in the middle of it.
      directed_steps.push_back(register_step(REG_COLUMN_COUNT, 3'd2));
      directed_steps.push_back(register_step(REG_ROW_COUNT, 3'd1));
      directed_steps.push_back(element_step(32'd5));
      directed_steps.push_back(element_step(32'd6));
      directed_steps.push_back(register_step(REG_SPARE_2, 3'd0));
      directed_steps.push_back(element_step(32'hffff_fffb));
      directed_steps.push_back(checked_step(32'h7fff_ffff, 2,
         make_word(32'h0000_0000, KIND_SUM, 2'd0, 2'd0, 1'b1, 1'b0),
         make_word(32'h8000_0005, KIND_SUM, 2'd0, 2'd1, 1'b1, 1'b1)));
      directed_steps.push_back(register_step(REG_SPARE_3, 3'd5));

      foreach (directed_steps[i]) begin
         if (directed_steps[i].op == STEP_REGISTER) begin
            write_register(directed_steps[i].index, directed_steps[i].data);
         end else begin
            send_element(directed_steps[i].value, directed_steps[i].typed_count == 0);
            if (directed_steps[i].typed_count > 0)
               pending_words.push_back(directed_steps[i].typed_first);
            if (directed_steps[i].typed_count > 1)
               pending_words.push_back(directed_steps[i].typed_second);
         end
      end

      // Random phases: new sizes, whole runs, now and then a broken load.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         quiet_spell = ($urandom_range(0, 3) == 0);
         rows_data = pick_size();
         cols_data = pick_size();
         if ($urandom_range(0, 1) == 0) begin
            write_register(REG_ROW_COUNT, rows_data);
            write_register(REG_COLUMN_COUNT, cols_data);
         end else begin
            write_register(REG_COLUMN_COUNT, cols_data);
            write_register(REG_ROW_COUNT, rows_data);
         end
         if ($urandom_range(0, 5) == 0)
            write_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                           CFG_W'($urandom_range(0, 7)));
         total = effective_size(rows_data) * effective_size(cols_data);
         runs  = (total > 8) ? 1 : $urandom_range(1, 3);
         for (int r = 0; r < runs; r++) begin
            for (int i = 0; i < 2 * total; i++) begin
               send_element(pick_element(), 1'b1);
               sent++;
            end
         end
         if (total > 1 && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 2 * total - 1)) begin
               send_element(pick_element(), 1'b1);
               sent++;
            end
         end
      end

      // Drain and finish.
      wait_idle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
